[design/ajr_pkg.sv]
// ---------------------------------------------------------------------------
// ajr_pkg - shared constants for the audio jitter ring
// Ring geometry, widths, command codes and register indexes.
// ---------------------------------------------------------------------------
package ajr_pkg;

    localparam int RING_DEPTH  = 4096;
    localparam int HALF_FRAMES = 64;

    localparam int IDX_W  = $clog2(RING_DEPTH);
    localparam int LVL_W  = 13;
    localparam int N_W    = $clog2(HALF_FRAMES + 1);
    localparam int K_W    = (HALF_FRAMES > 1) ? $clog2(HALF_FRAMES) : 1;
    localparam int WORD_W = 32;
    localparam int CNT_W  = 32;
    localparam int CMD_W  = 2;
    localparam int CFG_W  = 13;
    localparam int CFGI_W = 2;

    // output tdata: word, accepted, fill level, underrun total, zero pad
    localparam int OUT_USED = WORD_W + 1 + LVL_W + CNT_W;
    localparam int OUT_W    = ((OUT_USED + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PLAY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

    localparam logic [CFGI_W-1:0] REG_PACED  = 2'd0;
    localparam logic [CFGI_W-1:0] REG_COUNT  = 2'd1;
    localparam logic [CFGI_W-1:0] REG_LIMIT  = 2'd2;
    localparam logic [CFGI_W-1:0] REG_REFILL = 2'd3;

    localparam logic [LVL_W-1:0] LIMIT_RESET  = 13'd2048;
    localparam logic [LVL_W-1:0] REFILL_RESET = 13'd1024;

endpackage

[design/audio_jitter_ring_with_refill.sv]
// ---------------------------------------------------------------------------
// audio_jitter_ring_with_refill - stereo jitter buffer on a sample ring
// Pushes frames into a ring memory and plays them out a half buffer at a time.
// ---------------------------------------------------------------------------
// Items enter on the s_ channel: s_tuser carries the command, s_tdata the
// frame (left low, right high). Results leave on the m_ channel, one per push,
// read or unused command and HALF_FRAMES per play command, m_tlast on the last.
// A push, a read-and-clear or an unused command has its result registered the
// cycle after acceptance. A play command walks the ring memory frame by frame
// (read issue, then load of the output register from the registered read data).
// Only one item is worked on at a time; the input is ready again once the last
// result of the item sits in the output register and it is free. Config writes
// go through cfg_we/cfg_index/cfg_data; the user must make them only while
// idle, the block itself does not enforce it.
// Reset clears indexes, fill level and underrun count, sets the refill flag and
// loads register defaults; the ring memory itself is not cleared since only
// written entries are ever read. A stalled receiver holds the output register
// and the play walk waits for it; no result is lost or repeated.
// ---------------------------------------------------------------------------
module audio_jitter_ring_with_refill
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_we,
    input  logic [ajr_pkg::CFGI_W-1:0]   cfg_index,
    input  logic [ajr_pkg::CFG_W-1:0]    cfg_data,

    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [31:0]                  s_tdata,    // left_sample, right_sample
    input  logic [ajr_pkg::CMD_W-1:0]    s_tuser,    // cmd

    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [ajr_pkg::OUT_W-1:0]    m_tdata,    // out_left, out_right, accepted,
                                                     // fill_level, underrun_total, pad
    output logic                         m_tlast
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    // ring memory
    logic [ajr_pkg::WORD_W-1:0] sample_mem [ajr_pkg::RING_DEPTH];
    logic [ajr_pkg::WORD_W-1:0] rd_data_reg;
    logic                       mem_we;
    logic                       mem_re;

    // control state
    logic [1:0]                 state_reg,    state_next;
    logic [ajr_pkg::IDX_W-1:0]  widx_reg,     widx_next;
    logic [ajr_pkg::IDX_W-1:0]  ridx_reg,     ridx_next;
    logic [ajr_pkg::LVL_W-1:0]  fq_reg,       fq_next;
    logic                       refill_reg,   refill_next;
    logic [ajr_pkg::CNT_W-1:0]  under_reg,    under_next;
    logic [ajr_pkg::N_W-1:0]    play_n_reg,   play_n_next;
    logic [ajr_pkg::K_W-1:0]    k_reg,        k_next;

    // config registers
    logic                       paced_reg;
    logic                       count_en_reg;
    logic [ajr_pkg::LVL_W-1:0]  limit_reg;
    logic [ajr_pkg::LVL_W-1:0]  refill_lvl_reg;

    // output register
    logic                       out_valid_reg, out_valid_next;
    logic [ajr_pkg::WORD_W-1:0] out_word_reg,  out_word_next;
    logic                       out_acc_reg,   out_acc_next;
    logic [ajr_pkg::LVL_W-1:0]  out_fill_reg,  out_fill_next;
    logic [ajr_pkg::CNT_W-1:0]  out_total_reg, out_total_next;
    logic                       out_last_reg,  out_last_next;

    logic                       out_free;
    logic                       in_acc;
    logic                       push_ok;
    logic                       silent;
    logic [ajr_pkg::N_W-1:0]    n_calc;
    logic                       k_active;
    logic                       k_last;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign in_acc   = s_tvalid && s_tready;

    // effective limit is min(ring_limit, depth)
    assign push_ok  = (fq_reg < limit_reg)
                   && (fq_reg < ajr_pkg::LVL_W'(ajr_pkg::RING_DEPTH));
    assign silent   = refill_reg && (fq_reg < refill_lvl_reg);
    assign n_calc   = silent ? '0
                    : (fq_reg < ajr_pkg::LVL_W'(ajr_pkg::HALF_FRAMES))
                      ? fq_reg[ajr_pkg::N_W-1:0]
                      : ajr_pkg::N_W'(ajr_pkg::HALF_FRAMES);

    assign k_active = ajr_pkg::N_W'(k_reg) < play_n_reg;
    assign k_last   = k_reg == ajr_pkg::K_W'(ajr_pkg::HALF_FRAMES - 1);

    assign mem_we   = in_acc && (s_tuser == ajr_pkg::CMD_PUSH) && push_ok;
    assign mem_re   = (state_reg == ST_READ) && k_active;

    always_comb
    begin
        state_next     = state_reg;
        widx_next      = widx_reg;
        ridx_next      = ridx_reg;
        fq_next        = fq_reg;
        refill_next    = refill_reg;
        under_next     = under_reg;
        play_n_next    = play_n_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_word_next  = out_word_reg;
        out_acc_next   = out_acc_reg;
        out_fill_next  = out_fill_reg;
        out_total_next = out_total_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    out_word_next  = '0;
                    out_acc_next   = 1'b0;
                    out_fill_next  = fq_reg;
                    out_total_next = '0;
                    out_last_next  = 1'b1;
                    case (s_tuser)
                        ajr_pkg::CMD_PUSH:
                        begin
                            out_valid_next = 1'b1;
                            if (push_ok)
                            begin
                                widx_next     = (widx_reg == ajr_pkg::IDX_W'(ajr_pkg::RING_DEPTH - 1))
                                              ? '0 : widx_reg + 1'b1;
                                fq_next       = fq_reg + 1'b1;
                                out_acc_next  = 1'b1;
                                out_fill_next = fq_reg + 1'b1;
                            end
                        end
                        ajr_pkg::CMD_PLAY:
                        begin
                            play_n_next = n_calc;
                            fq_next     = fq_reg - ajr_pkg::LVL_W'(n_calc);
                            k_next      = '0;
                            state_next  = ST_READ;
                            if (refill_reg && !silent)
                            begin
                                refill_next = 1'b0;
                            end
                            // short half: pad, go back to refilling
                            if (!silent && (n_calc < ajr_pkg::N_W'(ajr_pkg::HALF_FRAMES)))
                            begin
                                refill_next = 1'b1;
                                if (count_en_reg)
                                begin
                                    under_next = under_reg + 1'b1;
                                end
                            end
                        end
                        ajr_pkg::CMD_READ:
                        begin
                            out_valid_next = 1'b1;
                            out_total_next = under_reg;
                            under_next     = '0;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                if (k_active)
                begin
                    ridx_next = (ridx_reg == ajr_pkg::IDX_W'(ajr_pkg::RING_DEPTH - 1))
                              ? '0 : ridx_reg + 1'b1;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = (k_active && paced_reg) ? rd_data_reg : '0;
                    out_acc_next   = 1'b0;
                    out_fill_next  = fq_reg;
                    out_total_next = '0;
                    out_last_next  = k_last;
                    if (k_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sample_mem[widx_reg] <= s_tdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= sample_mem[ridx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            widx_reg       <= '0;
            ridx_reg       <= '0;
            fq_reg         <= '0;
            refill_reg     <= 1'b1;
            under_reg      <= '0;
            play_n_reg     <= '0;
            k_reg          <= '0;
            out_valid_reg  <= 1'b0;
            paced_reg      <= 1'b1;
            count_en_reg   <= 1'b0;
            limit_reg      <= ajr_pkg::LIMIT_RESET;
            refill_lvl_reg <= ajr_pkg::REFILL_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            widx_reg      <= widx_next;
            ridx_reg      <= ridx_next;
            fq_reg        <= fq_next;
            refill_reg    <= refill_next;
            under_reg     <= under_next;
            play_n_reg    <= play_n_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    ajr_pkg::REG_PACED:  paced_reg      <= cfg_data[0];
                    ajr_pkg::REG_COUNT:  count_en_reg   <= cfg_data[0];
                    ajr_pkg::REG_LIMIT:  limit_reg      <= cfg_data;
                    ajr_pkg::REG_REFILL: refill_lvl_reg <= cfg_data;
                    default:             paced_reg      <= paced_reg;
                endcase
            end
        end
    end

    // output payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        out_acc_reg   <= out_acc_next;
        out_fill_reg  <= out_fill_next;
        out_total_reg <= out_total_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {(ajr_pkg::OUT_W - ajr_pkg::OUT_USED)'(0),
                       out_total_reg, out_fill_reg, out_acc_reg, out_word_reg};

endmodule
